>>> sv/assert_macros.svh
// Assertion macros shared by the cache evictor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SBCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SBCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SBCE_ASSERT(lbl, prop, msg)
`define SBCE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/sbce_pkg.sv
package sbce_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int SUM_W     = 32 + CNT_W;
  localparam int KEY_W     = 64;
  localparam int HDL_W     = 32;
  localparam int SIZE_W    = 32;
  localparam int TIME_W    = 48;
  localparam int BUDGET_W  = 36;
  localparam int CMP_W     = ((SUM_W > BUDGET_W) ? SUM_W : BUDGET_W) + 1;
  localparam int CNT_OUT_W = 5;
  localparam int POLICY_W  = 2;
  localparam int CMD_W     = 3;
  localparam int PROD_W    = 80;
  localparam int CFG_IDX_W = 1;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(32 * 1024 * 1024);

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_STORE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RETRIEVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TRIM     = 3'd5;

  // Victim policies.
  localparam logic [POLICY_W-1:0] POL_LRU      = 2'd0;
  localparam logic [POLICY_W-1:0] POL_SIZE     = 2'd1;
  localparam logic [POLICY_W-1:0] POL_SIZE_AGE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 1'd1;

  typedef enum logic [2:0] {
    OP_STORE, OP_RETRIEVE, OP_CONTAINS, OP_REMOVE, OP_CLEAR, OP_TRIM, OP_NOP
  } op_e;

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_EVICT} state_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [HDL_W-1:0]  handle;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] now;
  } work_t;

  // Queue head as seen by the engine.
  typedef struct packed {
    logic  valid;
    work_t item;
  } head_t;

  // Saturate the running sum to the reported width.
  function automatic logic [BUDGET_W-1:0] sat_total(logic [SUM_W-1:0] s);
    logic [BUDGET_W-1:0] r;
    if (CMP_W'(s) > CMP_W'({BUDGET_W{1'b1}})) r = '1;
    else r = BUDGET_W'(s);
    return r;
  endfunction

endpackage

>>> sv/sbce_if.sv
// Channel interfaces of the cache evictor.
interface sbce_in_if;
  import sbce_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_W-1:0]    key;
  logic [HDL_W-1:0]    code_handle;
  logic [SIZE_W-1:0]   code_size;
  logic [TIME_W-1:0]   now;
  modport source (output valid, command, key, code_handle, code_size, now, input ready);
  modport sink (input valid, command, key, code_handle, code_size, now, output ready);
endinterface

interface sbce_out_if;
  import sbce_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 hit;
  logic [KEY_W-1:0]     result_key;
  logic [HDL_W-1:0]     result_handle;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [BUDGET_W-1:0]  total_size;
  logic                 table_full;
  logic                 last;
  modport source (output valid, kind, hit, result_key, result_handle, entry_count,
                  total_size, table_full, last, input ready);
  modport sink (input valid, kind, hit, result_key, result_handle, entry_count,
                total_size, table_full, last, output ready);
endinterface

interface sbce_cfg_if;
  import sbce_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BUDGET_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/sbce_front.sv
`include "assert_macros.svh"
module sbce_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sbce_in_if.sink       in_i,
  input  logic          pop_i,
  output sbce_pkg::head_t head_o
);
  import sbce_pkg::*;

  work_t             q_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;
  work_t             dec;

  // Classify the incoming word into an operation.
  always_comb begin
    dec.key    = in_i.key;
    dec.handle = in_i.code_handle;
    dec.size   = in_i.code_size;
    dec.now    = in_i.now;
    unique case (in_i.command)
      CMD_STORE:    dec.op = OP_STORE;
      CMD_RETRIEVE: dec.op = OP_RETRIEVE;
      CMD_CONTAINS: dec.op = OP_CONTAINS;
      CMD_REMOVE:   dec.op = OP_REMOVE;
      CMD_CLEAR:    dec.op = OP_CLEAR;
      CMD_TRIM:     dec.op = OP_TRIM;
      default:      dec.op = OP_NOP;
    endcase
  end

  assign in_i.ready    = (cnt_q != QCNT_W'(QDEPTH));
  assign push          = in_i.valid && in_i.ready;
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.item   = q_q[rd_q];
  assign pop           = pop_i && head_o.valid;

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= dec;
  end

  `SBCE_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QDEPTH), "queue count overflow")
  `SBCE_ASSERT(a_no_empty_pop, pop_i |-> head_o.valid, "pop from empty queue")
  `SBCE_ASSERT(a_cnt_step, (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1,
               "queue count did not follow a push")
endmodule

>>> sv/sbce_back.sv
`include "assert_macros.svh"
module sbce_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbce_pkg::head_t head_i,
  output logic            pop_o,
  sbce_cfg_if.sink        cfg_i,
  sbce_out_if.source      out_o
);
  import sbce_pkg::*;

  state_e state_q, state_d;
  work_t  cur_q, cur_d;

  logic [POLICY_W-1:0] pol_q;
  logic [BUDGET_W-1:0] budget_q;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [KEY_W-1:0]   key_q  [ENTRIES];
  logic [HDL_W-1:0]   hdl_q  [ENTRIES];
  logic [SIZE_W-1:0]  size_q [ENTRIES];
  logic [TIME_W-1:0]  time_q [ENTRIES];
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [IDX_W-1:0]  scan_q, scan_d, best_q, best_d;
  logic              best_v_q, best_v_d, ph_q, ph_d;
  logic [PROD_W-1:0] best_m_q, best_m_d;
  logic [63:0]       plo_q, plo_d;

  logic                 ov_q, ov_d, okind_q, okind_d, ohit_q, ohit_d;
  logic                 ofull_q, ofull_d, olast_q, olast_d;
  logic [KEY_W-1:0]     okey_q, okey_d;
  logic [HDL_W-1:0]     ohdl_q, ohdl_d;
  logic [CNT_OUT_W-1:0] ocnt_q, ocnt_d;
  logic [BUDGET_W-1:0]  otot_q, otot_d;

  logic              out_free, match, free_found, wr_en, tw_en, over, step_done;
  logic [IDX_W-1:0]  match_idx, free_idx, rd_idx, wr_idx;
  logic [TIME_W-1:0] age, tw_val;
  logic [PROD_W-1:0] metric;
  logic [SIZE_W-1:0] pending;

  assign out_free = !ov_q || out_o.ready;

  // Parallel key match and free slot search, lowest slot first.
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    free_found = 1'b0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == head_i.item.key) begin
        match     = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // One read port into the slot table.
  always_comb begin
    unique case (state_q)
      ST_IDLE: rd_idx = match_idx;
      ST_SCAN: rd_idx = scan_q;
      default: rd_idx = best_q;
    endcase
  end

  // Victim metric: larger wins.
  always_comb begin
    age = (cur_q.now >= time_q[rd_idx]) ? cur_q.now - time_q[rd_idx] : '0;
    plo_d = size_q[rd_idx] * age[31:0];
    unique case (pol_q)
      POL_SIZE:     metric = PROD_W'(size_q[rd_idx]);
      POL_SIZE_AGE: metric = PROD_W'(plo_q)
                             + (PROD_W'(size_q[rd_idx] * age[TIME_W-1:32]) << 32);
      default:      metric = PROD_W'(~time_q[rd_idx]);
    endcase
    step_done = (pol_q != POL_SIZE_AGE) || ph_q;
  end

  assign pending = (cur_q.op == OP_STORE) ? cur_q.size : '0;
  assign over    = (CMP_W'(sum_q) + CMP_W'(pending)) > CMP_W'(budget_q);

  // Engine: next state and outputs.
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    valid_d  = valid_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    scan_d   = scan_q;
    best_d   = best_q;
    best_v_d = best_v_q;
    best_m_d = best_m_q;
    ph_d     = ph_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = free_idx;
    tw_en    = 1'b0;
    tw_val   = head_i.item.now;
    ov_d     = ov_q && !out_o.ready;
    okind_d  = okind_q;
    ohit_d   = ohit_q;
    okey_d   = okey_q;
    ohdl_d   = ohdl_q;
    ocnt_d   = ocnt_q;
    otot_d   = otot_q;
    ofull_d  = ofull_q;
    olast_d  = olast_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o   = 1'b1;
          cur_d   = head_i.item;
          ov_d    = 1'b1;
          okind_d = 1'b1;
          ohit_d  = 1'b0;
          okey_d  = '0;
          ohdl_d  = '0;
          ofull_d = 1'b0;
          olast_d = 1'b1;
          unique case (head_i.item.op)
            OP_STORE: begin
              ov_d = 1'b0;
              if (match) begin
                valid_d[match_idx] = 1'b0;
                sum_d = sum_q - SUM_W'(size_q[rd_idx]);
                cnt_d = cnt_q - 1'b1;
              end
              state_d = ST_CHECK;
            end
            OP_TRIM: begin
              ov_d    = 1'b0;
              state_d = ST_CHECK;
            end
            OP_RETRIEVE: begin
              ohit_d = match;
              if (match) begin
                tw_en  = 1'b1;
                ohdl_d = hdl_q[rd_idx];
              end
            end
            OP_CONTAINS: ohit_d = match;
            OP_REMOVE: begin
              ohit_d = match;
              if (match) begin
                valid_d[match_idx] = 1'b0;
                sum_d = sum_q - SUM_W'(size_q[rd_idx]);
                cnt_d = cnt_q - 1'b1;
              end
            end
            OP_CLEAR: begin
              valid_d = '0;
              sum_d   = '0;
              cnt_d   = '0;
            end
            default: ;
          endcase
          ocnt_d = CNT_OUT_W'(cnt_d);
          otot_d = sat_total(sum_d);
        end
      end
      ST_CHECK: begin
        if (over && cnt_q != '0) begin
          scan_d   = '0;
          best_v_d = 1'b0;
          ph_d     = 1'b0;
          state_d  = ST_SCAN;
        end else if (out_free) begin
          ov_d    = 1'b1;
          okind_d = 1'b1;
          ohit_d  = 1'b0;
          okey_d  = '0;
          ohdl_d  = '0;
          olast_d = 1'b1;
          ofull_d = 1'b0;
          if (cur_q.op == OP_STORE) begin
            if (free_found) begin
              wr_en = 1'b1;
              valid_d[free_idx] = 1'b1;
              sum_d = sum_q + SUM_W'(cur_q.size);
              cnt_d = cnt_q + 1'b1;
            end else begin
              ofull_d = 1'b1;
            end
          end
          ocnt_d  = CNT_OUT_W'(cnt_d);
          otot_d  = sat_total(sum_d);
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        ph_d = !step_done;
        if (step_done) begin
          if (valid_q[scan_q] && (!best_v_q || metric > best_m_q)) begin
            best_v_d = 1'b1;
            best_d   = scan_q;
            best_m_d = metric;
          end
          if (scan_q == IDX_W'(ENTRIES - 1)) state_d = ST_EVICT;
          else scan_d = scan_q + 1'b1;
        end
      end
      ST_EVICT: begin
        if (out_free) begin
          valid_d[best_q] = 1'b0;
          sum_d   = sum_q - SUM_W'(size_q[rd_idx]);
          cnt_d   = cnt_q - 1'b1;
          ov_d    = 1'b1;
          okind_d = 1'b0;
          ohit_d  = 1'b0;
          okey_d  = key_q[rd_idx];
          ohdl_d  = hdl_q[rd_idx];
          ofull_d = 1'b0;
          olast_d = 1'b0;
          ocnt_d  = CNT_OUT_W'(cnt_d);
          otot_d  = sat_total(sum_d);
          state_d = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
      ph_q     <= 1'b0;
      best_v_q <= 1'b0;
      scan_q   <= '0;
      pol_q    <= POL_LRU;
      budget_q <= BUDGET_RESET;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
      ph_q     <= ph_d;
      best_v_q <= best_v_d;
      scan_q   <= scan_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_POLICY: pol_q <= cfg_i.data[POLICY_W-1:0];
          REG_BUDGET: budget_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers and slot table.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    best_q   <= best_d;
    best_m_q <= best_m_d;
    plo_q    <= plo_d;
    okind_q  <= okind_d;
    ohit_q   <= ohit_d;
    okey_q   <= okey_d;
    ohdl_q   <= ohdl_d;
    ocnt_q   <= ocnt_d;
    otot_q   <= otot_d;
    ofull_q  <= ofull_d;
    olast_q  <= olast_d;
    if (wr_en) begin
      key_q[wr_idx]  <= cur_q.key;
      hdl_q[wr_idx]  <= cur_q.handle;
      size_q[wr_idx] <= cur_q.size;
      time_q[wr_idx] <= cur_q.now;
    end else if (tw_en) begin
      time_q[match_idx] <= tw_val;
    end
  end

  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = ov_q;
  assign out_o.kind          = okind_q;
  assign out_o.hit           = ohit_q;
  assign out_o.result_key    = okey_q;
  assign out_o.result_handle = ohdl_q;
  assign out_o.entry_count   = ocnt_q;
  assign out_o.total_size    = otot_q;
  assign out_o.table_full    = ofull_q;
  assign out_o.last          = olast_q;

  `SBCE_ASSERT(a_cnt_match, cnt_q == CNT_W'($countones(valid_q)), "count out of step")
  `SBCE_ASSERT(a_scan_nonempty, state_q == ST_SCAN |-> cnt_q != '0, "scan of empty table")
  `SBCE_ASSERT(a_evict_valid, state_q == ST_EVICT |-> best_v_q && valid_q[best_q],
               "victim not a valid slot")
  `SBCE_ASSERT(a_pop_idle, pop_o |-> state_q == ST_IDLE, "pop while busy")
endmodule

>>> sv/size_budget_cache_evictor_top.sv
// Size-budget cache evictor, 16-slot table.
// Retrieve, contains, remove, clear: result in the cycle after the engine takes the word.
// Store and trim pass a check state, then per victim a scan of every slot and an evict step;
// the scan takes one slot per cycle, but size-times-age registers a partial product first.
// Throughput: one command at a time in the engine; a 2-word queue takes input meanwhile.
// Reset: asynchronous, active low; table empty, policy least recent, budget 32 MiB.
module size_budget_cache_evictor_top (
  input logic         clk_i,
  input logic         rst_ni,
  sbce_in_if.sink     in_i,
  sbce_cfg_if.sink    cfg_i,
  sbce_out_if.source  out_o
);
  import sbce_pkg::*;

  head_t head;
  logic  pop;

  // Command intake and queue.
  sbce_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  // Lookup, eviction and result engine.
  sbce_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cfg_i  (cfg_i),
    .out_o  (out_o)
  );
endmodule
